// ===== rtl/core/httk_pkg.sv =====
package httk_pkg;

	localparam int MAX_HEADERS_DEF   = 32;
	localparam int METHOD_BYTES_DEF  = 16;
	localparam int PATH_BYTES_DEF    = 256;
	localparam int VERSION_BYTES_DEF = 16;
	localparam int KEY_BYTES_DEF     = 64;
	localparam int VALUE_BYTES_DEF   = 256;

	localparam logic [7:0] BYTE_NUL   = 8'h00;
	localparam logic [7:0] BYTE_NL    = 8'h0A;
	localparam logic [7:0] BYTE_SP    = 8'h20;
	localparam logic [7:0] BYTE_COLON = 8'h3A;

	// field kind codes
	localparam logic [2:0] KIND_DROP    = 3'd0;
	localparam logic [2:0] KIND_METHOD  = 3'd1;
	localparam logic [2:0] KIND_PATH    = 3'd2;
	localparam logic [2:0] KIND_VERSION = 3'd3;
	localparam logic [2:0] KIND_KEY     = 3'd4;
	localparam logic [2:0] KIND_VALUE   = 3'd5;

	// status codes reported with done_res
	localparam logic [1:0] STATUS_OK           = 2'd0;
	localparam logic [1:0] STATUS_BAD_REQ_LINE = 2'd1;
	localparam logic [1:0] STATUS_TOO_MANY_HDR = 2'd2;

	// header_part codes in a header line
	localparam logic [1:0] HPART_KEY   = 2'd0;
	localparam logic [1:0] HPART_SKIP  = 2'd1;
	localparam logic [1:0] HPART_VALUE = 2'd2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0] field_kind;
		logic [7:0] byte_out;
		logic [5:0] header_slot;
		logic [7:0] position;
		logic       keep;
		logic       header_commit;
		logic       done_res;
		logic [1:0] status;
	} out_item_t;

	typedef struct packed {
		logic       in_request_line;
		logic       line_started;
		logic [1:0] token_count;
		logic       in_token;
		logic [1:0] header_part;
		logic [6:0] header_count;
		logic [7:0] field_offset;
		logic       offset_over;
		logic       finished;
	} tok_state_t;

	localparam tok_state_t TOK_STATE_RESET = '{
		in_request_line: 1'b1,
		line_started:    1'b0,
		token_count:     2'd0,
		in_token:        1'b0,
		header_part:     HPART_KEY,
		header_count:    7'd0,
		field_offset:    8'd0,
		offset_over:     1'b0,
		finished:        1'b0
	};

endpackage

// ===== rtl/core/http_request_tokenizer.sv =====
// http request tokenizer
// in channel: one request byte per item (data_byte, last_byte) on in_valid / in_ready
// out channel: one label per byte (kind, slot, position, keep, commit, done, status)
//   on out_valid / out_ready, in the order the bytes were taken
// path: a taken byte sits in the input register, and its result is then loaded into
//   the result register and shown from there
// throughput: one byte per cycle while out_ready does not hold the result register;
//   the per-byte step is a single short pass over the tokenizer state
// stall: when out_ready is low the result register holds its item, the input
//   register keeps one more byte, and in_ready then drops until the result leaves
// reset: arst_n clears the tokenizer to the start of a request and empties
//   both registers
// after a zero byte, a last flag or an error status the request is over: further
//   bytes give all-zero labels carrying the byte, until the next reset
module http_request_tokenizer #(
	parameter int MAX_HEADERS   = httk_pkg::MAX_HEADERS_DEF,
	parameter int METHOD_BYTES  = httk_pkg::METHOD_BYTES_DEF,
	parameter int PATH_BYTES    = httk_pkg::PATH_BYTES_DEF,
	parameter int VERSION_BYTES = httk_pkg::VERSION_BYTES_DEF,
	parameter int KEY_BYTES     = httk_pkg::KEY_BYTES_DEF,
	parameter int VALUE_BYTES   = httk_pkg::VALUE_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  httk_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output httk_pkg::out_item_t out_item
);
	import httk_pkg::*;

	// input register
	logic       valid_s1;
	in_item_t   item_s1;

	// tokenizer state and result register
	tok_state_t state_q;
	tok_state_t state_next;
	out_item_t  step_res;
	out_item_t  out_q;
	logic       out_valid_q;

	logic       advance;

	// the buffered byte moves on when the result register is free or emptying
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	httk_step #(
		.MAX_HEADERS   (MAX_HEADERS),
		.METHOD_BYTES  (METHOD_BYTES),
		.PATH_BYTES    (PATH_BYTES),
		.VERSION_BYTES (VERSION_BYTES),
		.KEY_BYTES     (KEY_BYTES),
		.VALUE_BYTES   (VALUE_BYTES)
	) u_step (
		.state      (state_q),
		.item       (item_s1),
		.state_next (state_next),
		.result     (step_res)
	);

	// state advances exactly once per byte, when its result is loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= TOK_STATE_RESET;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= step_res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

// ===== rtl/core/httk_step.sv =====
module httk_step #(
	parameter int MAX_HEADERS   = httk_pkg::MAX_HEADERS_DEF,
	parameter int METHOD_BYTES  = httk_pkg::METHOD_BYTES_DEF,
	parameter int PATH_BYTES    = httk_pkg::PATH_BYTES_DEF,
	parameter int VERSION_BYTES = httk_pkg::VERSION_BYTES_DEF,
	parameter int KEY_BYTES     = httk_pkg::KEY_BYTES_DEF,
	parameter int VALUE_BYTES   = httk_pkg::VALUE_BYTES_DEF
) (
	input  httk_pkg::tok_state_t state,
	input  httk_pkg::in_item_t   item,
	output httk_pkg::tok_state_t state_next,
	output httk_pkg::out_item_t  result
);
	import httk_pkg::*;

	localparam logic [8:0] LIM_METHOD  = 9'(METHOD_BYTES - 1);
	localparam logic [8:0] LIM_PATH    = 9'(PATH_BYTES - 1);
	localparam logic [8:0] LIM_VERSION = 9'(VERSION_BYTES - 1);
	localparam logic [8:0] LIM_KEY     = 9'(KEY_BYTES);
	localparam logic [8:0] LIM_VALUE   = 9'(VALUE_BYTES);
	localparam logic [6:0] HDR_LIMIT   = 7'(MAX_HEADERS);

	tok_state_t st;
	out_item_t  res;
	logic [7:0] b;
	logic       is_end;
	logic       is_term;
	logic [8:0] lim;

	always_comb begin
		st      = state;
		res     = '0;
		b       = item.data_byte;
		is_end  = (b == BYTE_NUL) || item.last_byte;
		is_term = (b == BYTE_NL) || is_end;
		lim     = LIM_VERSION;
		res.byte_out = b;

		if (!st.finished) begin
			if (b != BYTE_NL && b != BYTE_NUL) begin
				// first byte of a non-empty line
				if (!st.line_started) begin
					st.line_started = 1'b1;
					st.in_token     = 1'b0;
					st.header_part  = HPART_KEY;
					st.token_count  = 2'd0;
					st.field_offset = 8'd0;
					st.offset_over  = 1'b0;
					if (!st.in_request_line && st.header_count >= HDR_LIMIT) begin
						res.done_res = 1'b1;
						res.status   = STATUS_TOO_MANY_HDR;
						st.finished  = 1'b1;
					end
				end

				if (st.finished) begin
					// overflow byte is dropped
				end else if (st.in_request_line) begin
					if (b == BYTE_SP) begin
						st.in_token = 1'b0;
					end else begin
						if (!st.in_token) begin
							st.in_token = 1'b1;
							if (st.token_count != 2'd3) begin
								st.token_count  = st.token_count + 2'd1;
								st.field_offset = 8'd0;
								st.offset_over  = 1'b0;
							end else begin
								st.header_part = HPART_SKIP;
							end
						end
						if (st.header_part == HPART_KEY) begin
							case (st.token_count)
								2'd1:    lim = LIM_METHOD;
								2'd2:    lim = LIM_PATH;
								default: lim = LIM_VERSION;
							endcase
							res.field_kind = {1'b0, st.token_count};
							res.position   = st.field_offset;
							res.keep       = !st.offset_over && ({1'b0, st.field_offset} < lim);
							if (st.field_offset == 8'hFF) st.offset_over = 1'b1;
							else st.field_offset = st.field_offset + 8'd1;
						end
					end
				end else if (st.header_part == HPART_KEY) begin
					if (b == BYTE_COLON) begin
						st.header_part = HPART_SKIP;
					end else begin
						res.field_kind  = KIND_KEY;
						res.header_slot = st.header_count[5:0];
						res.position    = st.field_offset;
						res.keep        = !st.offset_over && ({1'b0, st.field_offset} < LIM_KEY);
						if (st.field_offset == 8'hFF) st.offset_over = 1'b1;
						else st.field_offset = st.field_offset + 8'd1;
					end
				end else if (st.header_part == HPART_SKIP) begin
					st.header_part  = HPART_VALUE;
					st.field_offset = 8'd0;
					st.offset_over  = 1'b0;
				end else begin
					res.field_kind  = KIND_VALUE;
					res.header_slot = st.header_count[5:0];
					res.position    = st.field_offset;
					res.keep        = !st.offset_over && ({1'b0, st.field_offset} < LIM_VALUE);
					if (st.field_offset == 8'hFF) st.offset_over = 1'b1;
					else st.field_offset = st.field_offset + 8'd1;
				end
			end

			// line end, and request end which closes an open line first
			if (!st.finished && is_term) begin
				if (st.line_started) begin
					st.line_started = 1'b0;
					if (st.in_request_line) begin
						st.in_request_line = 1'b0;
						if (st.token_count != 2'd3) begin
							res.done_res = 1'b1;
							res.status   = STATUS_BAD_REQ_LINE;
							st.finished  = 1'b1;
						end
					end else if (st.header_part != HPART_KEY) begin
						res.header_commit = 1'b1;
						st.header_count   = st.header_count + 7'd1;
					end
				end
				if (!st.finished && is_end) begin
					res.done_res = 1'b1;
					res.status   = STATUS_OK;
					st.finished  = 1'b1;
				end
			end
		end

		state_next = st;
		result     = res;
	end

endmodule

// ===== dv/tb_http_request_tokenizer.sv =====
`timescale 1ns / 1ps

import httk_pkg::*;

// scoreboard: tracks the tokenizer state from the bytes taken in and
// holds the labels those bytes must come back with
class label_scoreboard;
	int unsigned mismatches;
	out_item_t   pending_labels[$];

	// tokenizer state as the block should hold it
	bit         in_req_line;
	bit         line_open;
	logic [1:0] tokens;
	bit         in_tok;
	logic [1:0] hpart;
	int         hdr_count;
	logic [7:0] offset;
	bit         offset_over;
	bit         ended;

	function new();
		mismatches  = 0;
		in_req_line = 1'b1;
		line_open   = 1'b0;
		tokens      = 2'd0;
		in_tok      = 1'b0;
		hpart       = HPART_KEY;
		hdr_count   = 0;
		offset      = 8'd0;
		offset_over = 1'b0;
		ended       = 1'b0;
	endfunction

	// {keep, position} for the current byte, then move the field offset on
	function logic [8:0] step_offset(int limit);
		logic [8:0] r;
		r = {(!offset_over && int'(offset) < limit), offset};
		if (offset == 8'd255)
			offset_over = 1'b1;
		else
			offset++;
		return r;
	endfunction

	function out_item_t label_byte(in_item_t it);
		out_item_t  r;
		logic [7:0] b;
		int         limit;
		r          = '0;
		b          = it.data_byte;
		r.byte_out = b;
		if (ended)
			return r;
		if (b != BYTE_NL && b != BYTE_NUL) begin
			if (!line_open) begin
				line_open   = 1'b1;
				in_tok      = 1'b0;
				hpart       = HPART_KEY;
				tokens      = 2'd0;
				offset      = 8'd0;
				offset_over = 1'b0;
				if (!in_req_line && hdr_count >= MAX_HEADERS_DEF) begin
					r.done_res = 1'b1;
					r.status   = STATUS_TOO_MANY_HDR;
					ended      = 1'b1;
				end
			end
			if (ended) begin
				// the byte that reports the overflow stays dropped
			end else if (in_req_line) begin
				if (b == BYTE_SP) begin
					in_tok = 1'b0;
				end else begin
					if (!in_tok) begin
						in_tok = 1'b1;
						if (tokens < 2'd3) begin
							tokens++;
							offset      = 8'd0;
							offset_over = 1'b0;
						end else begin
							hpart = HPART_SKIP;
						end
					end
					if (hpart == HPART_KEY) begin
						case (tokens)
							2'd1: begin
								r.field_kind = KIND_METHOD;
								limit        = METHOD_BYTES_DEF - 1;
							end
							2'd2: begin
								r.field_kind = KIND_PATH;
								limit        = PATH_BYTES_DEF - 1;
							end
							default: begin
								r.field_kind = KIND_VERSION;
								limit        = VERSION_BYTES_DEF - 1;
							end
						endcase
						{r.keep, r.position} = step_offset(limit);
					end
				end
			end else if (hpart == HPART_KEY) begin
				if (b == BYTE_COLON) begin
					hpart = HPART_SKIP;
				end else begin
					r.field_kind         = KIND_KEY;
					r.header_slot        = 6'(hdr_count);
					{r.keep, r.position} = step_offset(KEY_BYTES_DEF);
				end
			end else if (hpart == HPART_SKIP) begin
				hpart       = HPART_VALUE;
				offset      = 8'd0;
				offset_over = 1'b0;
			end else begin
				r.field_kind         = KIND_VALUE;
				r.header_slot        = 6'(hdr_count);
				{r.keep, r.position} = step_offset(VALUE_BYTES_DEF);
			end
		end
		if (!ended && (b == BYTE_NL || b == BYTE_NUL || it.last_byte)) begin
			if (line_open) begin
				line_open = 1'b0;
				if (in_req_line) begin
					in_req_line = 1'b0;
					if (tokens < 2'd3) begin
						r.done_res = 1'b1;
						r.status   = STATUS_BAD_REQ_LINE;
						ended      = 1'b1;
					end
				end else if (hpart != HPART_KEY) begin
					r.header_commit = 1'b1;
					hdr_count++;
				end
			end
			if (!ended && (b == BYTE_NUL || it.last_byte)) begin
				r.done_res = 1'b1;
				r.status   = STATUS_OK;
				ended      = 1'b1;
			end
		end
		return r;
	endfunction

	function void note_byte(in_item_t it);
		pending_labels.push_back(label_byte(it));
	endfunction

	function void check_label(out_item_t got);
		out_item_t want;
		if (pending_labels.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: label %h arrived with nothing pending", got);
			return;
		end
		want = pending_labels.pop_front();
		if (got.field_kind !== want.field_kind || got.byte_out !== want.byte_out ||
				got.header_slot !== want.header_slot || got.position !== want.position ||
				got.keep !== want.keep || got.header_commit !== want.header_commit ||
				got.done_res !== want.done_res || got.status !== want.status) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display({"mismatch: expected kind %0d byte %h slot %0d pos %0d",
					" keep %b commit %b done %b status %0d"},
					want.field_kind, want.byte_out, want.header_slot, want.position,
					want.keep, want.header_commit, want.done_res, want.status);
				$display({"          actual   kind %0d byte %h slot %0d pos %0d",
					" keep %b commit %b done %b status %0d"},
					got.field_kind, got.byte_out, got.header_slot, got.position,
					got.keep, got.header_commit, got.done_res, got.status);
			end
		end
	endfunction
endclass

module tb_http_request_tokenizer;

	// receiver holds off this long once, after this many labels, to fill the block
	localparam int HOLD_AT     = 20;
	localparam int HOLD_CYCLES = 120;
	// bytes offered after the request has ended
	localparam int TAIL_BYTES  = 40;
	// the run is padded with trailing bytes up to this many items
	localparam int ITEMS       = 1400;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_item;

	label_scoreboard labels = new();

	// whole request as it goes to the block, built before traffic starts
	in_item_t request_bytes[$];
	int       pause_at;
	// stretches where a side never idles
	bit       send_calm = 1'b0;
	bit       take_calm = 1'b0;

	http_request_tokenizer #(
		.MAX_HEADERS  (MAX_HEADERS_DEF),
		.METHOD_BYTES (METHOD_BYTES_DEF),
		.PATH_BYTES   (PATH_BYTES_DEF),
		.VERSION_BYTES(VERSION_BYTES_DEF),
		.KEY_BYTES    (KEY_BYTES_DEF),
		.VALUE_BYTES  (VALUE_BYTES_DEF)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

	always #5 clk = ~clk;

	function automatic void put(logic [7:0] b, logic fin);
		in_item_t it;
		it.data_byte = b;
		it.last_byte = fin;
		request_bytes.push_back(it);
	endfunction

	// any byte that does not end a line or the request
	function automatic logic [7:0] pick_byte(bit no_space, bit no_colon);
		logic [7:0] b;
		do
			b = 8'($urandom_range(1, 255));
		while (b == BYTE_NL || (no_space && b == BYTE_SP) || (no_colon && b == BYTE_COLON));
		return b;
	endfunction

	function automatic void put_run(int n, bit no_space, bit no_colon);
		for (int i = 0; i < n; i++)
			put(pick_byte(no_space, no_colon), 1'b0);
	endfunction

	// one request per run, since reset comes only once:
	// mostly a full request that runs into the header limit or ends in mid-line,
	// now and then a bad request line or a request with no non-empty line
	task automatic build_request();
		int pick;
		int stored;
		int goal;
		int ending;
		bit to_overflow;
		pick = $urandom_range(0, 15);
		// empty lines ahead of the request line are skipped
		put(BYTE_NL, 1'b0);
		put(BYTE_NL, 1'b0);
		if (pick == 0) begin
			// request line with fewer than three tokens, maybe only spaces
			put(BYTE_SP, 1'b0);
			repeat ($urandom_range(0, 2)) begin
				put_run($urandom_range(1, 6), 1'b1, 1'b0);
				put(BYTE_SP, 1'b0);
			end
			if ($urandom_range(0, 1))
				put(BYTE_NL, 1'b0);
			else
				put(BYTE_SP, 1'b1);
		end else if (pick == 1) begin
			// nothing but empty lines, ended by a zero byte or the last flag
			repeat ($urandom_range(0, 3))
				put(BYTE_NL, 1'b0);
			if ($urandom_range(0, 1))
				put(BYTE_NUL, 1'b0);
			else
				put(BYTE_NL, 1'b1);
		end else begin
			// request line: leading spaces, space runs, method past its limit at times,
			// a path past 255 bytes now and then, extra tokens that get dropped
			repeat ($urandom_range(0, 2))
				put(BYTE_SP, 1'b0);
			put(8'hFF, 1'b0);
			put(8'h01, 1'b0);
			put_run($urandom_range(0, 18), 1'b1, 1'b0);
			repeat ($urandom_range(1, 3))
				put(BYTE_SP, 1'b0);
			put_run(($urandom_range(0, 3) == 0) ? $urandom_range(250, 300) : $urandom_range(1, 30),
				1'b1, 1'b0);
			repeat ($urandom_range(1, 3))
				put(BYTE_SP, 1'b0);
			put_run($urandom_range(1, 20), 1'b1, 1'b0);
			repeat ($urandom_range(0, 2)) begin
				repeat ($urandom_range(1, 3))
					put(BYTE_SP, 1'b0);
				put_run($urandom_range(1, 5), 1'b1, 1'b0);
			end
			repeat ($urandom_range(0, 2))
				put(BYTE_SP, 1'b0);
			put(BYTE_NL, 1'b0);

			// header lines
			to_overflow = $urandom_range(0, 1);
			goal        = to_overflow ? MAX_HEADERS_DEF : $urandom_range(MAX_HEADERS_DEF - 8,
				MAX_HEADERS_DEF - 1);
			stored      = 0;
			while (stored < goal) begin
				if (stored == 2) begin
					// key past its limit and a value whose offset saturates
					put_run(70, 1'b0, 1'b1);
					put(BYTE_COLON, 1'b0);
					put(BYTE_SP, 1'b0);
					put_run($urandom_range(256, 300), 1'b0, 1'b0);
					put(BYTE_NL, 1'b0);
					stored++;
					continue;
				end
				case ($urandom_range(0, 15))
					0: begin
						repeat ($urandom_range(1, 2))
							put(BYTE_NL, 1'b0);
					end
					1: begin
						// no colon: labelled as key but never stored
						put_run($urandom_range(1, 15), 1'b0, 1'b1);
						put(BYTE_NL, 1'b0);
					end
					2: begin
						// colon closes the line, value empty
						put_run($urandom_range(0, 5), 1'b0, 1'b1);
						put(BYTE_COLON, 1'b0);
						put(BYTE_NL, 1'b0);
						stored++;
					end
					3: begin
						// only the skipped byte after the colon
						put_run($urandom_range(0, 5), 1'b0, 1'b1);
						put(BYTE_COLON, 1'b0);
						put(BYTE_SP, 1'b0);
						put(BYTE_NL, 1'b0);
						stored++;
					end
					default: begin
						put_run($urandom_range(0, 20), 1'b0, 1'b1);
						put(BYTE_COLON, 1'b0);
						put(($urandom_range(0, 3) != 0) ? BYTE_SP : pick_byte(1'b0, 1'b0), 1'b0);
						put_run($urandom_range(0, 40), 1'b0, 1'b0);
						put(BYTE_NL, 1'b0);
						stored++;
					end
				endcase
			end

			if (to_overflow) begin
				// one more non-empty line after the table is full
				repeat ($urandom_range(0, 2))
					put(BYTE_NL, 1'b0);
				put_run($urandom_range(1, 8), 1'b0, 1'b0);
				put(BYTE_NL, 1'b0);
			end else begin
				// request ends inside an open line
				put_run($urandom_range(1, 5), 1'b0, 1'b1);
				ending = $urandom_range(0, 3);
				if (ending != 3) begin
					put(BYTE_COLON, 1'b0);
					put(BYTE_SP, 1'b0);
					put_run($urandom_range(0, 5), 1'b0, 1'b0);
				end
				case (ending)
					0, 3: put(pick_byte(1'b0, ending == 3), 1'b1);
					1: put(BYTE_NUL, 1'b0);
					default: put(BYTE_NL, 1'b1);
				endcase
			end
		end
		// once the request is over every byte must come back unlabelled;
		// short requests get a longer tail so that every run has about the same length
		repeat (TAIL_BYTES)
			put(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		while (request_bytes.size() < ITEMS)
			put(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		pause_at = request_bytes.size() / 2;
	endtask

	// sender: valid rises at a falling edge and stays up until the item is taken
	task automatic send_bytes();
		int idle;
		for (int i = 0; i < request_bytes.size(); i++) begin
			idle = send_calm ? 0 : $urandom_range(0, 14);
			if ($urandom_range(0, 31) == 0)
				send_calm = !send_calm;
			if (i == pause_at) begin
				// let the block drain completely before going on
				in_valid <= 1'b0;
				do
					@(negedge clk);
				while (labels.pending_labels.size() != 0);
			end else if (idle > 0) begin
				in_valid <= 1'b0;
				repeat (idle)
					@(negedge clk);
			end
			in_valid <= 1'b1;
			in_item  <= request_bytes[i];
			do
				@(posedge clk);
			while (!in_ready);
			labels.note_byte(request_bytes[i]);
			@(negedge clk);
		end
		in_valid <= 1'b0;
	endtask

	// receiver: random stalls, one long hold-off counted here to back up the input
	task automatic take_labels();
		int idle;
		int taken;
		taken = 0;
		forever begin
			if (taken == HOLD_AT) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES)
					@(negedge clk);
			end else begin
				idle = take_calm ? 0 : $urandom_range(0, 14);
				if ($urandom_range(0, 31) == 0)
					take_calm = !take_calm;
				if (idle > 0) begin
					out_ready <= 1'b0;
					repeat (idle)
						@(negedge clk);
				end
			end
			out_ready <= 1'b1;
			do
				@(posedge clk);
			while (!out_valid);
			labels.check_label(out_item);
			taken++;
			@(negedge clk);
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_item   = '0;
		out_ready = 1'b0;
		build_request();
		repeat (11)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		fork
			take_labels();
		join_none
		send_bytes();
		// drain, then wait for any stray label to show up
		while (labels.pending_labels.size() != 0)
			@(posedge clk);
		repeat (8)
			@(posedge clk);
		if (labels.mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule

// ===== http_request_tokenizer.f =====
rtl/core/httk_pkg.sv
rtl/core/httk_step.sv
rtl/core/http_request_tokenizer.sv
dv/tb_http_request_tokenizer.sv
